### rtl/assert_macros.svh
// assert_macros.svh: concurrent assertion wrappers for the clique search core.
// No dependencies; expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MCS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MCS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MCS_ASSERT_IMP(label, ante, cons, msg)
`define MCS_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

### rtl/mcs_pkg.sv
// mcs_pkg: widths, item opcodes, micro-op codes and the control store
// of the maximum clique search core. No dependencies.
package mcs_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int VERTEX_W         = 6;
    localparam int COUNT_W          = 7;
    localparam int OPCODE_W         = 2;
    localparam int UPC_W            = 5;

    typedef logic [UPC_W-1:0] upc_t;

    // item opcodes
    localparam logic [OPCODE_W-1:0] OPC_CLEAR  = 2'd0;
    localparam logic [OPCODE_W-1:0] OPC_EDGE   = 2'd1;
    localparam logic [OPCODE_W-1:0] OPC_SEARCH = 2'd2;

    // datapath micro-ops
    typedef enum logic [3:0] {
        OP_NOP,
        OP_IDLE,
        OP_CLEAR,
        OP_RD_A,
        OP_WR_A,
        OP_WR_B,
        OP_INIT,
        OP_TEST,
        OP_BOUND,
        OP_PUSH,
        OP_POP,
        OP_RESTORE,
        OP_EMIT_EMPTY,
        OP_EMIT
    } uop_t;

    // jump conditions; taken: target or opcode dispatch; else step counter advances
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_DISPATCH,
        C_NO_EXTEND,
        C_DEPTH_ZERO,
        C_BEST_SET,
        C_SCAN_MORE
    } cond_t;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        upc_t  target;
    } ctrl_t;

    // program entry points
    localparam upc_t U_IDLE   = 5'd0;
    localparam upc_t U_CLEAR  = 5'd1;
    localparam upc_t U_EDGE   = 5'd2;
    localparam upc_t U_SEARCH = 5'd5;
    localparam upc_t U_TEST   = 5'd6;
    localparam upc_t U_POP    = 5'd10;
    localparam upc_t U_REPORT = 5'd13;
    localparam upc_t U_EMIT   = 5'd15;

    // control store
    function automatic ctrl_t ucode(input upc_t addr);
        ctrl_t cw;
        case (addr)
            5'd0:    cw = '{OP_IDLE,       C_DISPATCH,   U_IDLE};
            5'd1:    cw = '{OP_CLEAR,      C_ALWAYS,     U_IDLE};
            5'd2:    cw = '{OP_RD_A,       C_NEXT,       U_IDLE};
            5'd3:    cw = '{OP_WR_A,       C_NEXT,       U_IDLE};
            5'd4:    cw = '{OP_WR_B,       C_ALWAYS,     U_IDLE};
            5'd5:    cw = '{OP_INIT,       C_NEXT,       U_IDLE};
            5'd6:    cw = '{OP_TEST,       C_NEXT,       U_IDLE};
            5'd7:    cw = '{OP_BOUND,      C_NEXT,       U_IDLE};
            5'd8:    cw = '{OP_NOP,        C_NO_EXTEND,  U_POP};
            5'd9:    cw = '{OP_PUSH,       C_ALWAYS,     U_TEST};
            5'd10:   cw = '{OP_NOP,        C_DEPTH_ZERO, U_REPORT};
            5'd11:   cw = '{OP_POP,        C_NEXT,       U_IDLE};
            5'd12:   cw = '{OP_RESTORE,    C_ALWAYS,     U_TEST};
            5'd13:   cw = '{OP_NOP,        C_BEST_SET,   U_EMIT};
            5'd14:   cw = '{OP_EMIT_EMPTY, C_ALWAYS,     U_IDLE};
            5'd15:   cw = '{OP_EMIT,       C_SCAN_MORE,  U_EMIT};
            5'd16:   cw = '{OP_NOP,        C_ALWAYS,     U_IDLE};
            default: cw = '{OP_NOP,        C_ALWAYS,     U_IDLE};
        endcase
        return cw;
    endfunction

endpackage

### rtl/maximum_clique_search_core.sv
// maximum_clique_search_core: microcoded backtracking maximum clique search.
// Clear item: marks every row invalid. Add-edge item: read-modify-write of both rows.
// Search item: branch-and-bound descent with backtracking;
// then one result per cycle, lowest member first (a single empty result if the best clique is empty).
// Reset (async, rst_n low): graph empty, vertex_count 0, sequencer idle; no clearing pass.
// One item at a time, results never stall. Depends on mcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module maximum_clique_search_core
    import mcs_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [VERTEX_W-1:0] vertex_a,
    input  logic [VERTEX_W-1:0] vertex_b,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_data,
    output logic                result_valid,
    output logic [VERTEX_W-1:0] member_vertex,
    output logic [COUNT_W-1:0]  clique_size,
    output logic                empty_result,
    output logic                last
);

    localparam int N       = MAX_VERTICES;
    localparam int VW      = $clog2(N);
    localparam int DEPTH_W = $clog2(N + 1);
    localparam int BW      = $clog2(2 * N + 1);
    localparam int NG      = (N + 7) / 8;
    localparam int PADW    = NG * 8;
    localparam int GW      = 4;

    typedef logic [N-1:0] mask_t;

    // index of the single set bit of a one-hot word
    function automatic logic [VW-1:0] onehot_idx(input mask_t x);
        logic [VW-1:0] idx;
        idx = '0;
        for (int i = 0; i < N; i++) begin
            if (x[i]) begin
                idx = idx | VW'(i);
            end
        end
        return idx;
    endfunction

    // sequencer and control registers
    upc_t                 upc_reg, upc_next;
    logic [COUNT_W-1:0]   vcount_reg, vcount_next;
    mask_t                row_valid_reg, row_valid_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic [DEPTH_W-1:0]   bsize_reg, bsize_next;
    logic                 result_valid_reg, result_valid_next;

    // datapath registers
    logic [VW-1:0]        a_reg, a_next;
    logic [VW-1:0]        b_reg, b_next;
    logic                 edge_ok_reg, edge_ok_next;
    mask_t                all_reg, all_next;
    mask_t                cand_reg, cand_next;
    mask_t                cur_reg, cur_next;
    mask_t                best_reg, best_next;
    logic [VW-1:0]        vtx_reg, vtx_next;
    logic [GW-1:0]        grp_reg [NG];
    logic [GW-1:0]        grp_next [NG];
    logic [BW-1:0]        bound_reg, bound_next;
    logic [VERTEX_W-1:0]  member_reg, member_next;
    logic [COUNT_W-1:0]   size_reg, size_next;
    logic                 empty_reg, empty_next;
    logic                 last_reg, last_next;

    // adjacency memory and stack memory
    mask_t                adj_mem [N];
    mask_t                adj_rd_reg;
    logic                 adj_rdv_reg;
    logic                 adj_we, adj_re;
    logic [VW-1:0]        adj_waddr, adj_raddr;
    mask_t                adj_wdata;

    logic [VW-1:0]        stk_v_mem [N];
    mask_t                stk_c_mem [N];
    logic [VW-1:0]        stk_v_rd_reg;
    mask_t                stk_c_rd_reg;
    logic                 stk_we, stk_re;
    logic [VW-1:0]        stk_waddr, stk_raddr;
    logic [VW-1:0]        stk_wv;
    mask_t                stk_wc;

    // combinational helpers
    ctrl_t                cw;
    logic                 take;
    mask_t                row;
    mask_t                cand_low, scan_low, scan_rem, vtx_bit, all_w;
    logic [VW-1:0]        cand_idx;
    logic                 extend;
    logic [DEPTH_W-1:0]   depth_inc, depth_dec;
    logic [COUNT_W-1:0]   n_sat;
    logic [PADW-1:0]      cand_pad;
    logic [GW-1:0]        grp_w [NG];
    logic [BW-1:0]        bound_w;

    // shared decode terms
    always_comb
    begin
        cw        = ucode(upc_reg);
        row       = adj_rdv_reg ? adj_rd_reg : '0;
        cand_low  = cand_reg & (~cand_reg + 1'b1);
        cand_idx  = onehot_idx(cand_low);
        scan_low  = best_reg & (~best_reg + 1'b1);
        scan_rem  = best_reg & ~scan_low;
        vtx_bit   = mask_t'(1) << vtx_reg;
        depth_inc = depth_reg + 1'b1;
        depth_dec = depth_reg - 1'b1;
        extend    = (cand_reg != '0) && (depth_reg < DEPTH_W'(N))
                    && (bound_reg > BW'(bsize_reg));
        n_sat     = (vcount_reg > COUNT_W'(N)) ? COUNT_W'(N) : vcount_reg;
        for (int i = 0; i < N; i++) begin
            all_w[i] = (COUNT_W'(i) < n_sat);
        end
    end

    // candidate popcount, first level: one count per byte
    always_comb
    begin
        cand_pad = PADW'(cand_reg);
        for (int g = 0; g < NG; g++) begin
            grp_w[g] = '0;
            for (int k = 0; k < 8; k++) begin
                grp_w[g] = grp_w[g] + GW'(cand_pad[g * 8 + k]);
            end
        end
    end

    // second level: depth plus byte counts
    always_comb
    begin
        bound_w = BW'(depth_reg);
        for (int g = 0; g < NG; g++) begin
            bound_w = bound_w + BW'(grp_reg[g]);
        end
    end

    // sequencer: conditional jump or step
    always_comb
    begin
        case (cw.cond)
            C_NEXT:       take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_DISPATCH:   take = 1'b1;
            C_NO_EXTEND:  take = !extend;
            C_DEPTH_ZERO: take = (depth_reg == '0);
            C_BEST_SET:   take = (bsize_reg != '0);
            C_SCAN_MORE:  take = (scan_rem != '0);
            default:      take = 1'b0;
        endcase

        if (cw.cond == C_DISPATCH) begin
            upc_next = U_IDLE;
            if (start) begin
                case (opcode)
                    OPC_CLEAR:  upc_next = U_CLEAR;
                    OPC_EDGE:   upc_next = U_EDGE;
                    OPC_SEARCH: upc_next = U_SEARCH;
                    default:    upc_next = U_IDLE;
                endcase
            end
        end else if (take) begin
            upc_next = cw.target;
        end else begin
            upc_next = upc_reg + 1'b1;
        end
    end

    // datapath driven by the current control word
    always_comb
    begin
        vcount_next       = cfg_we ? cfg_data : vcount_reg;
        row_valid_next    = row_valid_reg;
        depth_next        = depth_reg;
        bsize_next        = bsize_reg;
        result_valid_next = 1'b0;
        a_next            = a_reg;
        b_next            = b_reg;
        edge_ok_next      = edge_ok_reg;
        all_next          = all_reg;
        cand_next         = cand_reg;
        cur_next          = cur_reg;
        best_next         = best_reg;
        vtx_next          = vtx_reg;
        grp_next          = grp_reg;
        bound_next        = bound_reg;
        member_next       = member_reg;
        size_next         = size_reg;
        empty_next        = empty_reg;
        last_next         = last_reg;
        adj_we            = 1'b0;
        adj_re            = 1'b0;
        adj_waddr         = a_reg;
        adj_raddr         = a_reg;
        adj_wdata         = '0;
        stk_we            = 1'b0;
        stk_re            = 1'b0;
        stk_waddr         = depth_reg[VW-1:0];
        stk_raddr         = depth_dec[VW-1:0];
        stk_wv            = vtx_reg;
        stk_wc            = cand_reg & ~vtx_bit;

        case (cw.op)
            // latch edge operands on accept
            OP_IDLE:
            begin
                if (start) begin
                    a_next       = vertex_a[VW-1:0];
                    b_next       = vertex_b[VW-1:0];
                    edge_ok_next = (int'(vertex_a) < N) && (int'(vertex_b) < N);
                end
            end
            OP_CLEAR:
            begin
                row_valid_next = '0;
            end
            OP_RD_A:
            begin
                adj_re    = 1'b1;
                adj_raddr = a_reg;
            end
            // write row a, read row b
            OP_WR_A:
            begin
                adj_we    = edge_ok_reg;
                adj_waddr = a_reg;
                adj_wdata = row | (mask_t'(1) << b_reg);
                if (edge_ok_reg) begin
                    row_valid_next[a_reg] = 1'b1;
                end
                adj_re    = 1'b1;
                adj_raddr = b_reg;
            end
            OP_WR_B:
            begin
                adj_we    = edge_ok_reg;
                adj_waddr = b_reg;
                adj_wdata = row | (mask_t'(1) << a_reg);
                if (edge_ok_reg) begin
                    row_valid_next[b_reg] = 1'b1;
                end
            end
            OP_INIT:
            begin
                all_next   = all_w;
                cand_next  = all_w;
                cur_next   = '0;
                best_next  = '0;
                bsize_next = '0;
                depth_next = '0;
            end
            // pick lowest candidate, fetch its row, count candidates
            OP_TEST:
            begin
                adj_re    = 1'b1;
                adj_raddr = cand_idx;
                vtx_next  = cand_idx;
                grp_next  = grp_w;
            end
            OP_BOUND:
            begin
                bound_next = bound_w;
            end
            // save remaining candidates, descend
            OP_PUSH:
            begin
                stk_we     = 1'b1;
                cur_next   = cur_reg | vtx_bit;
                cand_next  = stk_wc & row & all_reg;
                depth_next = depth_inc;
                if (depth_inc > bsize_reg) begin
                    bsize_next = depth_inc;
                    best_next  = cur_reg | vtx_bit;
                end
            end
            OP_POP:
            begin
                stk_re     = 1'b1;
                depth_next = depth_dec;
            end
            OP_RESTORE:
            begin
                cand_next = stk_c_rd_reg;
                cur_next  = cur_reg & ~(mask_t'(1) << stk_v_rd_reg);
            end
            OP_EMIT_EMPTY:
            begin
                result_valid_next = 1'b1;
                member_next       = '0;
                size_next         = '0;
                empty_next        = 1'b1;
                last_next         = 1'b1;
            end
            // one member per cycle, lowest first
            OP_EMIT:
            begin
                result_valid_next = 1'b1;
                member_next       = VERTEX_W'(onehot_idx(scan_low));
                size_next         = COUNT_W'(bsize_reg);
                empty_next        = 1'b0;
                last_next         = (scan_rem == '0);
                best_next         = scan_rem;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            upc_reg          <= U_IDLE;
            vcount_reg       <= '0;
            row_valid_reg    <= '0;
            depth_reg        <= '0;
            bsize_reg        <= '0;
            result_valid_reg <= 1'b0;
        end else begin
            upc_reg          <= upc_next;
            vcount_reg       <= vcount_next;
            row_valid_reg    <= row_valid_next;
            depth_reg        <= depth_next;
            bsize_reg        <= bsize_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        edge_ok_reg <= edge_ok_next;
        all_reg     <= all_next;
        cand_reg    <= cand_next;
        cur_reg     <= cur_next;
        best_reg    <= best_next;
        vtx_reg     <= vtx_next;
        grp_reg     <= grp_next;
        bound_reg   <= bound_next;
        member_reg  <= member_next;
        size_reg    <= size_next;
        empty_reg   <= empty_next;
        last_reg    <= last_next;
    end

    // adjacency rows: one write, one registered read; invalid rows read as zero
    always_ff @(posedge clk)
    begin
        if (adj_we) begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        if (adj_re) begin
            adj_rd_reg  <= adj_mem[adj_raddr];
            adj_rdv_reg <= row_valid_reg[adj_raddr];
        end
    end

    // backtrack stack: chosen vertex and remaining candidates per depth
    always_ff @(posedge clk)
    begin
        if (stk_we) begin
            stk_v_mem[stk_waddr] <= stk_wv;
            stk_c_mem[stk_waddr] <= stk_wc;
        end
        if (stk_re) begin
            stk_v_rd_reg <= stk_v_mem[stk_raddr];
            stk_c_rd_reg <= stk_c_mem[stk_raddr];
        end
    end

    // ports
    assign busy          = (upc_reg != U_IDLE);
    assign result_valid  = result_valid_reg;
    assign member_vertex = member_reg;
    assign clique_size   = size_reg;
    assign empty_result  = empty_reg;
    assign last          = last_reg;

    // checks
    `MCS_ASSERT_NXT(a_search_busy, start && !busy && opcode == OPC_SEARCH, busy, "no start")
    `MCS_ASSERT_NXT(a_last_quiet, result_valid && last, !result_valid, "result after last")
    `MCS_ASSERT_IMP(a_depth_bound, busy, depth_reg <= DEPTH_W'(N), "stack depth overflow")
    `MCS_ASSERT_IMP(a_size_nz, result_valid && !empty_result, clique_size != '0, "member with size 0")

endmodule
